FILE: rtl/core/nat_rewrite_table_macros.svh
// Assertion macros used by the rewrite table back end.
`ifndef NAT_REWRITE_TABLE_MACROS_SVH
`define NAT_REWRITE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nat_rewrite_table: implication check failed");

// Next-cycle implication, checked outside reset.
`define NRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nat_rewrite_table: next-cycle check failed");

`endif

FILE: rtl/core/nrt_pkg.sv
// Types and constants shared by the rewrite table modules.
`default_nettype none

package nrt_pkg;

	// Default number of rules the table holds.
	localparam int unsigned TABLE_ENTRIES_DEF = 16;

	// Depth of the command queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Reset values of the port registers.
	localparam logic [15:0] WEB_SVC_RST = 16'd80;
	localparam logic [15:0] FILE_SVC_RST = 16'd21;
	localparam logic [15:0] WEB_PRX_RST = 16'd800;
	localparam logic [15:0] FILE_PRX_RST = 16'd210;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_WEB_SVC  = 2'd0,
		CFG_FILE_SVC = 2'd1,
		CFG_WEB_PRX  = 2'd2,
		CFG_FILE_PRX = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		STAT_DONE      = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_UNTOUCHED = 3'd2,
		STAT_IP        = 3'd3,
		STAT_IP_PORT   = 3'd4
	} status_t;

	// One rewrite rule.
	typedef struct packed {
		logic [31:0] cli_addr;
		logic [31:0] srv_addr;
		logic [15:0] cli_port;
		logic [15:0] srv_port;
		logic [15:0] proxy_port;
	} rule_t;

	// Classified command handed from front to back.
	typedef struct packed {
		op_t         op;
		rule_t       rule;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic        svc_en;
		logic        prx_en;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One result item.
	typedef struct packed {
		status_t     status;
		logic [31:0] ip;
		logic [15:0] port;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/nrt_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module nrt_queue import nrt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cmd_t    push_data,
	input  wire logic    pop,
	output cmd_t         head,
	output q_stat_t      q_stat
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	// Status and head of the queue.
	assign q_stat.full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);
	assign head         = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nrt_front.sv
// Front end: port registers, input transfer and lookup classification.
`default_nettype none

module nrt_front import nrt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] rule_client_ip,
	input  wire logic [31:0] rule_server_ip,
	input  wire logic [15:0] rule_client_port,
	input  wire logic [15:0] rule_server_port,
	input  wire logic [15:0] rule_proxy_port,
	input  wire logic [15:0] pkt_src_port,
	input  wire logic [31:0] pkt_dst_ip,
	input  wire logic [15:0] pkt_dst_port,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output cmd_t             push_data
);

	logic [15:0] web_svc_q;
	logic [15:0] file_svc_q;
	logic [15:0] web_prx_q;
	logic [15:0] file_prx_q;

	// Port registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			web_svc_q  <= WEB_SVC_RST;
			file_svc_q <= FILE_SVC_RST;
			web_prx_q  <= WEB_PRX_RST;
			file_prx_q <= FILE_PRX_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WEB_SVC:  web_svc_q  <= cfg_data;
				CFG_FILE_SVC: file_svc_q <= cfg_data;
				CFG_WEB_PRX:  web_prx_q  <= cfg_data;
				CFG_FILE_PRX: file_prx_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// An item is taken whenever the queue has room.
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	// Build the command and classify which lookups apply.
	always_comb begin
		push_data.op              = op_t'(opcode);
		push_data.rule.cli_addr   = rule_client_ip;
		push_data.rule.srv_addr   = rule_server_ip;
		push_data.rule.cli_port   = rule_client_port;
		push_data.rule.srv_port   = rule_server_port;
		push_data.rule.proxy_port = rule_proxy_port;
		push_data.src_port        = pkt_src_port;
		push_data.dst_ip          = pkt_dst_ip;
		push_data.dst_port        = pkt_dst_port;
		push_data.svc_en = (pkt_dst_port == web_svc_q) || (pkt_dst_port == file_svc_q);
		push_data.prx_en = (pkt_src_port == web_prx_q) || (pkt_src_port == file_prx_q);
	end

endmodule

`default_nettype wire

FILE: rtl/core/nrt_back.sv
// Back end: rule cells, parallel match, table update and result register.
`default_nettype none

`include "nat_rewrite_table_macros.svh"

module nrt_back import nrt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    q_head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output res_t         out_res
);

	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic {
		S_IDLE,
		S_RESOLVE
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	res_t                     out_res_q;
	rule_t                    rule_q [TABLE_ENTRIES];
	rule_t                    shift_up [TABLE_ENTRIES];
	rule_t                    shift_dn [TABLE_ENTRIES];
	cmd_t                     cmd_s1;
	logic [TABLE_ENTRIES-1:0] svc_vec_s1;
	logic [TABLE_ENTRIES-1:0] prx_vec_s1;
	logic [TABLE_ENTRIES-1:0] rm_vec_s1;
	logic [TABLE_ENTRIES-1:0] svc_hit;
	logic [TABLE_ENTRIES-1:0] prx_hit;
	logic [TABLE_ENTRIES-1:0] rm_hit;
	logic [TABLE_ENTRIES-1:0] svc_one;
	logic [TABLE_ENTRIES-1:0] prx_one;
	logic [TABLE_ENTRIES-1:0] rm_mask;
	logic [31:0]              svc_ip;
	logic [31:0]              prx_ip;
	logic [15:0]              prx_port;
	logic                     table_full;
	logic                     out_free;
	logic                     resolve;
	res_t                     res;

	// Cell 0 holds the newest rule; a cell is live below the count.
	always_comb begin
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			svc_hit[k] = (CNT_W'(k) < count_q) && q_head.svc_en
				&& (rule_q[k].proxy_port == q_head.src_port)
				&& (rule_q[k].srv_addr == q_head.dst_ip)
				&& (rule_q[k].srv_port == q_head.dst_port);
			prx_hit[k] = (CNT_W'(k) < count_q) && q_head.prx_en
				&& (rule_q[k].cli_addr == q_head.dst_ip)
				&& (rule_q[k].cli_port == q_head.dst_port);
			rm_hit[k] = (CNT_W'(k) < count_q) && (rule_q[k] == q_head.rule);
		end
	end

	// Sequencing: take a command, then resolve it into the result register.
	assign pop      = (state_q == S_IDLE) && !q_stat.empty;
	assign out_free = !out_valid_q || !out_stall;
	assign resolve  = (state_q == S_RESOLVE) && out_free;

	// Match vectors and the command move into stage one.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1     <= q_head;
			svc_vec_s1 <= svc_hit;
			prx_vec_s1 <= prx_hit;
			rm_vec_s1  <= rm_hit;
		end
	end

	// Newest match is the lowest set bit; removal shifts that cell and all above.
	assign svc_one    = svc_vec_s1 & (-svc_vec_s1);
	assign prx_one    = prx_vec_s1 & (-prx_vec_s1);
	assign rm_mask    = rm_vec_s1 | (-rm_vec_s1);
	assign table_full = (count_q == CNT_W'(TABLE_ENTRIES));

	// Select the fields of the winning rules.
	always_comb begin
		svc_ip   = '0;
		prx_ip   = '0;
		prx_port = '0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			svc_ip   = svc_ip | ({32{svc_one[k]}} & rule_q[k].cli_addr);
			prx_ip   = prx_ip | ({32{prx_one[k]}} & rule_q[k].srv_addr);
			prx_port = prx_port | ({16{prx_one[k]}} & rule_q[k].srv_port);
		end
	end

	// Result of the command in stage one.
	always_comb begin
		res.status = STAT_DONE;
		res.ip     = '0;
		res.port   = '0;
		case (cmd_s1.op)
			OP_ADD: begin
				res.status = table_full ? STAT_FULL : STAT_DONE;
			end
			OP_REMOVE, OP_CLEAR: begin
				res.status = STAT_DONE;
			end
			OP_LOOKUP: begin
				if (|svc_vec_s1) begin
					res.status = STAT_IP;
					res.ip     = svc_ip;
					res.port   = cmd_s1.src_port;
				end else if (|prx_vec_s1) begin
					res.status = STAT_IP_PORT;
					res.ip     = prx_ip;
					res.port   = prx_port;
				end else begin
					res.status = STAT_UNTOUCHED;
					res.port   = cmd_s1.src_port;
				end
			end
			default: ;
		endcase
	end

	// State, rule count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_RESOLVE;
					end
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				S_RESOLVE: begin
					if (resolve) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						out_res_q   <= res;
						case (cmd_s1.op)
							OP_ADD: begin
								if (!table_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_REMOVE: begin
								if (|rm_vec_s1) begin
									count_q <= count_q - 1'b1;
								end
							end
							OP_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Neighbor taps of every cell for the two shift directions.
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_tap
		localparam int unsigned PREV = (k == 0) ? 0 : k - 1;
		localparam int unsigned NEXT = (k + 1 < TABLE_ENTRIES) ? k + 1 : k;
		assign shift_up[k] = (k == 0) ? cmd_s1.rule : rule_q[PREV];
		assign shift_dn[k] = rule_q[NEXT];
	end

	// Rule cells: an add shifts every rule one place older, a removal closes the gap.
	always_ff @(posedge clk) begin
		if (resolve) begin
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				case (cmd_s1.op)
					OP_ADD: begin
						if (!table_full) begin
							rule_q[k] <= shift_up[k];
						end
					end
					OP_REMOVE: begin
						if (rm_mask[k]) begin
							rule_q[k] <= shift_dn[k];
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`NRT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_ENTRIES))
	`NRT_ASSERT_IMP(a_pop_when_idle, clk, arst_n, pop, state_q == S_IDLE)
	`NRT_ASSERT_IMP(a_result_after_resolve, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == S_RESOLVE)
	`NRT_ASSERT_NEXT(a_resolve_frees, clk, arst_n, resolve, state_q == S_IDLE && out_valid_q)
	`NRT_ASSERT_IMP(a_count_drop, clk, arst_n, count_q < $past(count_q),
		$past(cmd_s1.op) == OP_REMOVE || $past(cmd_s1.op) == OP_CLEAR)

endmodule

`default_nettype wire

FILE: rtl/core/nat_rewrite_table.sv
// Bounded table of proxy rewrite rules with header source lookup.
//
// Input channel: in_valid / in_stall with one item per transfer; opcode selects
// add rule, remove rule, clear table or look up one outgoing header. Output
// channel: out_valid / out_stall, one result (status, new_src_ip, new_src_port)
// per input item, in input order. The user must write the port registers
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce this. Items enter a two-entry command queue;
// the table engine then takes one item at a time: it compares all rules in
// parallel, then picks the newest match, updates the rule cells and loads the
// result register. It takes no new item from the queue until the last one is
// resolved.
// in_stall rises only while the command queue is full.
// Reset empties the table and the queue, drops out_valid and loads the port
// registers with 80, 21, 800 and 210.
// While out_stall holds a result, the engine keeps the next resolved item back
// and the queue goes on taking items until it is full.
`default_nettype none

module nat_rewrite_table import nrt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] rule_client_ip,
	input  wire logic [31:0] rule_server_ip,
	input  wire logic [15:0] rule_client_port,
	input  wire logic [15:0] rule_server_port,
	input  wire logic [15:0] rule_proxy_port,
	input  wire logic [15:0] pkt_src_port,
	input  wire logic [31:0] pkt_dst_ip,
	input  wire logic [15:0] pkt_dst_port,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      new_src_ip,
	output logic [15:0]      new_src_port
);

	logic    push;
	logic    pop;
	cmd_t    push_data;
	cmd_t    q_head;
	q_stat_t q_stat;
	res_t    out_res;

	// Front end: port registers and classification.
	nrt_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.rule_client_ip   (rule_client_ip),
		.rule_server_ip   (rule_server_ip),
		.rule_client_port (rule_client_port),
		.rule_server_port (rule_server_port),
		.rule_proxy_port  (rule_proxy_port),
		.pkt_src_port     (pkt_src_port),
		.pkt_dst_ip       (pkt_dst_ip),
		.pkt_dst_port     (pkt_dst_port),
		.q_stat           (q_stat),
		.push             (push),
		.push_data        (push_data)
	);

	// Command queue between the two halves.
	nrt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.q_stat    (q_stat)
	);

	// Table engine and result register.
	nrt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status       = out_res.status;
	assign new_src_ip   = out_res.ip;
	assign new_src_port = out_res.port;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the proxy rewrite rule table.
`timescale 1ns / 100ps

module tb_top;
	import nrt_pkg::*;

	localparam int TBL_DEPTH = TABLE_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RULE_POOL_MAX = 24;

	// One command as presented on the input channel.
	typedef struct {
		op_t         op;
		rule_t       rule;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
	} nat_req_t;

	// One expected result.
	typedef struct {
		status_t     status;
		logic [31:0] ip;
		logic [15:0] port;
	} nat_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = 2'd0;
	logic [31:0] rule_client_ip = 32'd0;
	logic [31:0] rule_server_ip = 32'd0;
	logic [15:0] rule_client_port = 16'd0;
	logic [15:0] rule_server_port = 16'd0;
	logic [15:0] rule_proxy_port = 16'd0;
	logic [15:0] pkt_src_port = 16'd0;
	logic [31:0] pkt_dst_ip = 32'd0;
	logic [15:0] pkt_dst_port = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] new_src_ip;
	logic [15:0] new_src_port;

	// Shadow of the rule table and the port registers.
	rule_t       rule_tbl [TBL_DEPTH];
	int          rule_count = 0;
	logic [15:0] port_reg [4];

	nat_req_t    req_pending_q[$];
	nat_rsp_t    rewrite_exp_q[$];
	rule_t       rule_pool[$];
	nat_req_t    drv_req;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int svc_rewrites = 0;
	int prx_rewrites = 0;
	int full_rejects = 0;
	int quiet_cycles = 0;

	nat_rewrite_table u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.rule_client_ip   (rule_client_ip),
		.rule_server_ip   (rule_server_ip),
		.rule_client_port (rule_client_port),
		.rule_server_port (rule_server_port),
		.rule_proxy_port  (rule_proxy_port),
		.pkt_src_port     (pkt_src_port),
		.pkt_dst_ip       (pkt_dst_ip),
		.pkt_dst_port     (pkt_dst_port),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.new_src_ip       (new_src_ip),
		.new_src_port     (new_src_port)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one command to the shadow table and return the result it must give.
	function automatic nat_rsp_t predict_rewrite(nat_req_t req);
		nat_rsp_t rsp;
		bit       hit;
		int       k;
		int       j;
		rsp.status = STAT_DONE;
		rsp.ip = 32'd0;
		rsp.port = 16'd0;
		hit = 1'b0;
		case (req.op)
			OP_ADD: begin
				if (rule_count >= TBL_DEPTH) begin
					rsp.status = STAT_FULL;
				end else begin
					rule_tbl[rule_count] = req.rule;
					rule_count++;
				end
			end
			OP_REMOVE: begin
				// Only the newest identical rule goes; newer rules close the gap.
				for (k = rule_count - 1; k >= 0 && !hit; k--) begin
					if (rule_tbl[k] == req.rule) begin
						hit = 1'b1;
						for (j = k; j < rule_count - 1; j++)
							rule_tbl[j] = rule_tbl[j + 1];
						rule_count--;
					end
				end
			end
			OP_CLEAR: begin
				rule_count = 0;
			end
			OP_LOOKUP: begin
				rsp.status = STAT_UNTOUCHED;
				rsp.port = req.src_port;
				// Traffic toward a service: restore the client address.
				if (req.dst_port == port_reg[CFG_WEB_SVC] ||
						req.dst_port == port_reg[CFG_FILE_SVC]) begin
					for (k = rule_count - 1; k >= 0 && !hit; k--) begin
						if (rule_tbl[k].proxy_port == req.src_port &&
								rule_tbl[k].srv_addr == req.dst_ip &&
								rule_tbl[k].srv_port == req.dst_port) begin
							hit = 1'b1;
							rsp.status = STAT_IP;
							rsp.ip = rule_tbl[k].cli_addr;
						end
					end
				end
				// Traffic from a proxy port: present the server address and port.
				if (!hit && (req.src_port == port_reg[CFG_WEB_PRX] ||
						req.src_port == port_reg[CFG_FILE_PRX])) begin
					for (k = rule_count - 1; k >= 0 && !hit; k--) begin
						if (rule_tbl[k].cli_addr == req.dst_ip &&
								rule_tbl[k].cli_port == req.dst_port) begin
							hit = 1'b1;
							rsp.status = STAT_IP_PORT;
							rsp.ip = rule_tbl[k].srv_addr;
							rsp.port = rule_tbl[k].srv_port;
						end
					end
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic rule_t mk_rule(logic [31:0] cip, logic [31:0] sip,
			logic [15:0] cport, logic [15:0] sport, logic [15:0] pport);
		rule_t r;
		r.cli_addr = cip;
		r.srv_addr = sip;
		r.cli_port = cport;
		r.srv_port = sport;
		r.proxy_port = pport;
		return r;
	endfunction

	function automatic rule_t rand_rule();
		return mk_rule($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	// Port values biased toward the configured ports and the extremes.
	function automatic logic [15:0] pick_port();
		case ($urandom_range(5))
			0: return port_reg[$urandom_range(3)];
			1: return 16'h0000;
			2: return 16'hFFFF;
			3: return 16'(1000 + $urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	// Addresses drawn mostly from a small set so that rules collide often.
	function automatic logic [31:0] pick_ip();
		case ($urandom_range(4))
			0, 1: return 32'h0A00_0000 + $urandom_range(3);
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic rule_t fresh_rule();
		logic [15:0] sport;
		sport = pick_port();
		if ($urandom_range(1))
			sport = $urandom_range(1) ? port_reg[CFG_WEB_SVC] : port_reg[CFG_FILE_SVC];
		return mk_rule(pick_ip(), pick_ip(), pick_port(), sport, pick_port());
	endfunction

	task automatic queue_req(input op_t op, input rule_t r, input logic [15:0] sp,
			input logic [31:0] dip, input logic [15:0] dp);
		nat_req_t req;
		req.op = op;
		req.rule = r;
		req.src_port = sp;
		req.dst_ip = dip;
		req.dst_port = dp;
		req_pending_q.push_back(req);
	endtask

	// Table update; the header fields carry noise.
	task automatic queue_rule_op(input op_t op, input rule_t r);
		queue_req(op, r, 16'($urandom), $urandom, 16'($urandom));
	endtask

	// Header lookup; the rule fields carry noise.
	task automatic queue_lookup(input logic [15:0] sp, input logic [31:0] dip,
			input logic [15:0] dp);
		queue_req(OP_LOOKUP, rand_rule(), sp, dip, dp);
	endtask

	// Mostly lookups and removals built from rules added earlier, plus adds, clears and noise.
	task automatic queue_random_req();
		rule_t r;
		int    pick;
		pick = $urandom_range(99);
		if (rule_pool.size() != 0 && $urandom_range(9) < 7)
			r = rule_pool[$urandom_range(rule_pool.size() - 1)];
		else
			r = fresh_rule();
		if (pick < 32) begin
			if ($urandom_range(3) != 0)
				r = fresh_rule();
			rule_pool.push_back(r);
			if (rule_pool.size() > RULE_POOL_MAX)
				void'(rule_pool.pop_front());
			queue_rule_op(OP_ADD, r);
		end else if (pick < 46) begin
			queue_rule_op(OP_REMOVE, r);
		end else if (pick < 49) begin
			queue_rule_op(OP_CLEAR, rand_rule());
		end else begin
			case ($urandom_range(4))
				0, 1: queue_lookup(r.proxy_port, r.srv_addr, r.srv_port);
				2, 3: queue_lookup($urandom_range(1) ? port_reg[CFG_FILE_PRX] :
					port_reg[CFG_WEB_PRX], r.cli_addr, r.cli_port);
				default: queue_lookup(pick_port(), pick_ip(), pick_port());
			endcase
		end
	endtask

	// Called on a rising edge; the write lands on the next one.
	task automatic write_port(input cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		port_reg[idx] = val;
		@(posedge clk);
	endtask

	// Return on a rising edge once every command has been answered.
	task automatic wait_drained();
		@(negedge clk);
		while (req_pending_q.size() != 0 || in_valid || rewrite_exp_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) queue_random_req();
		wait_drained();
	endtask

	// Input driver: predicts each transfer and presents the next command.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				rewrite_exp_q.push_back(predict_rewrite(drv_req));
			if (!in_valid || !in_stall) begin
				if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_req = req_pending_q.pop_front();
					in_valid <= 1'b1;
					opcode <= drv_req.op;
					rule_client_ip <= drv_req.rule.cli_addr;
					rule_server_ip <= drv_req.rule.srv_addr;
					rule_client_port <= drv_req.rule.cli_port;
					rule_server_port <= drv_req.rule.srv_port;
					rule_proxy_port <= drv_req.rule.proxy_port;
					pkt_src_port <= drv_req.src_port;
					pkt_dst_ip <= drv_req.dst_ip;
					pkt_dst_port <= drv_req.dst_port;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each output transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		nat_rsp_t want;
		if (arst_n) begin
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (rewrite_exp_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result status=%0d ip=%h port=%h",
							$realtime, status, new_src_ip, new_src_port);
					mismatch_count++;
				end else begin
					want = rewrite_exp_q.pop_front();
					results_checked++;
					if (want.status == STAT_IP)
						svc_rewrites++;
					if (want.status == STAT_IP_PORT)
						prx_rewrites++;
					if (want.status == STAT_FULL)
						full_rejects++;
					if (status !== want.status || new_src_ip !== want.ip ||
							new_src_port !== want.port) begin
						if (mismatch_count < 10)
							$display({"%0t: mismatch: expected status=%0d ip=%h port=%h,",
								" got status=%0d ip=%h port=%h"}, $realtime, want.status,
								want.ip, want.port, status, new_src_ip, new_src_port);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL nat_rewrite_table");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		rule_t a_rule;
		rule_t a_newer;
		rule_t b_rule;
		rule_t c_rule;
		int    i;
		port_reg[CFG_WEB_SVC] = WEB_SVC_RST;
		port_reg[CFG_FILE_SVC] = FILE_SVC_RST;
		port_reg[CFG_WEB_PRX] = WEB_PRX_RST;
		port_reg[CFG_FILE_PRX] = FILE_PRX_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks with the reset port settings.
		a_rule = mk_rule(32'hFFFF_FFFF, 32'hC0A8_0101, 16'hFFFF, WEB_SVC_RST, 16'd5000);
		a_newer = a_rule;
		a_newer.cli_addr = 32'h0A00_0001;
		b_rule = mk_rule(32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
		c_rule = mk_rule(32'h0A0A_0A0A, 32'h0808_0808, FILE_SVC_RST, 16'd443, 16'd7);
		// Lookup against an empty table.
		queue_lookup(16'd5000, 32'hC0A8_0101, WEB_SVC_RST);
		queue_rule_op(OP_ADD, a_rule);
		// Service-side hit, then proxy-side hit on the same rule.
		queue_lookup(16'd5000, 32'hC0A8_0101, WEB_SVC_RST);
		queue_lookup(WEB_PRX_RST, 32'hFFFF_FFFF, 16'hFFFF);
		queue_rule_op(OP_ADD, b_rule);
		queue_lookup(FILE_PRX_RST, 32'd0, 16'd0);
		// A newer rule with the same key wins.
		queue_rule_op(OP_ADD, a_newer);
		queue_lookup(16'd5000, 32'hC0A8_0101, WEB_SVC_RST);
		// Service port with no service match falls through to the proxy path.
		queue_rule_op(OP_ADD, c_rule);
		queue_lookup(FILE_PRX_RST, 32'h0A0A_0A0A, FILE_SVC_RST);
		queue_rule_op(OP_REMOVE, a_newer);
		queue_lookup(16'd5000, 32'hC0A8_0101, WEB_SVC_RST);
		// Removal that matches nothing leaves the table alone.
		queue_rule_op(OP_REMOVE, mk_rule(32'hFFFF_FFFF, 32'hC0A8_0101, 16'hFFFF,
			WEB_SVC_RST, 16'd5001));
		// Fill the table, then one add too many.
		for (i = 0; i < TBL_DEPTH - 3; i++)
			queue_rule_op(OP_ADD, mk_rule($urandom, $urandom, 16'(i), 16'(i), 16'(i)));
		queue_rule_op(OP_ADD, rand_rule());
		queue_rule_op(OP_CLEAR, rand_rule());
		queue_lookup(16'd5000, 32'hC0A8_0101, WEB_SVC_RST);
		wait_drained();

		// Random traffic under several port settings and flow-control patterns.
		run_phase(0, 0, 300);

		write_port(CFG_WEB_SVC, 16'h0000);
		write_port(CFG_FILE_SVC, 16'hFFFF);
		write_port(CFG_WEB_PRX, 16'hFFFF);
		write_port(CFG_FILE_PRX, 16'h0000);
		cfg_we <= 1'b0;
		run_phase(45, 0, 300);

		// Service ports equal to proxy ports, so both lookup paths apply at once.
		write_port(CFG_WEB_SVC, 16'd8080);
		write_port(CFG_FILE_SVC, 16'd21);
		write_port(CFG_WEB_PRX, 16'd8080);
		write_port(CFG_FILE_PRX, 16'd21);
		cfg_we <= 1'b0;
		run_phase(0, 45, 300);

		write_port(CFG_WEB_SVC, 16'($urandom));
		write_port(CFG_FILE_SVC, 16'($urandom));
		write_port(CFG_WEB_PRX, 16'($urandom));
		write_port(CFG_FILE_PRX, 16'($urandom));
		cfg_we <= 1'b0;
		run_phase(11, 11, 300);

		write_port(CFG_WEB_SVC, WEB_SVC_RST);
		write_port(CFG_FILE_SVC, FILE_SVC_RST);
		write_port(CFG_WEB_PRX, WEB_PRX_RST);
		write_port(CFG_FILE_PRX, FILE_PRX_RST);
		cfg_we <= 1'b0;
		run_phase(0, 0, 300);

		// Let any stray result show up before the verdict.
		repeat (10) @(posedge clk);
		mismatch_count += rewrite_exp_q.size();
		$display("Checked %0d results over five port settings, %0d mismatches.",
			results_checked, mismatch_count);
		$display("Seen: %0d service-side rewrites, %0d proxy-side rewrites, %0d full rejects.",
			svc_rewrites, prx_rewrites, full_rejects);
		if (mismatch_count == 0)
			$display("PASS nat_rewrite_table");
		else
			$display("FAIL nat_rewrite_table");
		$finish;
	end

endmodule
